/* src/pse_pkg.sv */
// shared types and constants for the postfix stack evaluator
`default_nettype none

package pse_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int WORD_W              = 32;
    localparam int ACTION_W            = 3;
    localparam int STATUS_W            = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_MOD  = 3'd5,
        ACT_POP  = 3'd6,
        ACT_NOP  = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FEW     = 2'd1,
        ST_FULL    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage

`default_nettype wire

/* src/postfix_stack_evaluator.sv */
// postfix evaluator top level: request sequencer, operand stack and output register
//
// s_axis: one request per handshake; tuser carries the action (push, add, sub,
//   mul, div, mod, pop, nop), tdata the 32-bit signed value used by push.
// m_axis: exactly one result per request; tdata holds the result value and the
//   stack depth after the step, tuser the status (ok, too few operands, stack
//   full, divide by zero). errors leave the stack untouched and return zero.
// one request is processed at a time; s_axis_tready is high only while idle.
// divide and modulo run a 32-step restoring divider in the shared arithmetic
//   unit, which sets the worst case; add, sub and mul go through the same unit
//   in one step.
// the result appears in the same cycle that s_axis_tready returns high.
// a stalled m_axis holds the finished result in the output register; the next
//   request may be accepted meanwhile but its result waits for the register.
// reset (synchronous, active low) empties the stack and drops any pending
//   result; stack contents themselves are not cleared.
`default_nettype none

module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1),
    localparam int ADDR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int M_DATA_W  = WORD_W + CNT_W,
    localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [WORD_W-1:0]    s_axis_tdata,   // value
    input  wire logic [ACTION_W-1:0]  s_axis_tuser,   // action
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,   // result_value, depth
    output logic      [STATUS_W-1:0]  m_axis_tuser    // status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_POP,
        S_DONE
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    action_t           action_reg, action_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] res_reg, res_next;
    status_t           status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_res_reg, m_res_next;
    status_t           m_status_reg, m_status_next;
    logic [CNT_W-1:0]  m_depth_reg, m_depth_next;

    action_t           in_action;
    logic              in_accept;
    logic              full;
    logic              few_two;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] top_data;
    logic [WORD_W-1:0] next_data;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    assign in_action     = action_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign full          = (count_reg == CNT_W'(STACK_DEPTH));
    assign few_two       = (count_reg < CNT_W'(2));
    assign cnt_m1        = count_reg - CNT_W'(1);
    assign cnt_m2        = count_reg - CNT_W'(2);

    pse_stack_mem #(
        .DEPTH (STACK_DEPTH)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (cnt_m1[ADDR_W-1:0]),
        .rd_addr_b (cnt_m2[ADDR_W-1:0]),
        .rd_data_a (top_data),
        .rd_data_b (next_data)
    );

    pse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .lhs     (next_data),
        .rhs     (top_data),
        .rsp     (alu_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg & ~m_axis_tready;
        m_res_next    = m_res_reg;
        m_status_next = m_status_reg;
        m_depth_next  = m_depth_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = s_axis_tdata;
        alu_req.start = 1'b0;
        case (action_reg)
            ACT_ADD: alu_req.op = ALU_ADD;
            ACT_SUB: alu_req.op = ALU_SUB;
            ACT_MUL: alu_req.op = ALU_MUL;
            ACT_DIV: alu_req.op = ALU_DIV;
            ACT_MOD: alu_req.op = ALU_MOD;
            default: alu_req.op = ALU_ADD;
        endcase
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    action_next = in_action;
                    res_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (in_action)
                        ACT_PUSH: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                res_next   = s_axis_tdata;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
                            if (few_two) begin
                                status_next = ST_FEW;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        ACT_POP: begin
                            if (count_reg == '0) begin
                                status_next = ST_FEW;
                            end else begin
                                state_next = S_POP;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                // operands are on the read ports now
                if ((action_reg == ACT_DIV || action_reg == ACT_MOD) && top_data == '0) begin
                    status_next = ST_DIVZERO;
                    state_next  = S_DONE;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = S_CALC;
                end
            end
            S_CALC: begin
                if (alu_rsp.done) begin
                    wr_en      = 1'b1;
                    wr_addr    = cnt_m2[ADDR_W-1:0];
                    wr_data    = alu_rsp.result;
                    res_next   = alu_rsp.result;
                    count_next = cnt_m1;
                    state_next = S_DONE;
                end
            end
            S_POP: begin
                res_next   = top_data;
                count_next = cnt_m1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_res_next    = res_reg;
                    m_status_next = status_reg;
                    m_depth_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        action_reg   <= action_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        m_res_reg    <= m_res_next;
        m_status_reg <= m_status_next;
        m_depth_reg  <= m_depth_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_depth_reg, m_res_reg});
    assign m_axis_tuser  = m_status_reg;

endmodule

`default_nettype wire

/* src/pse_stack_mem.sv */
// operand stack storage: one write port, two registered read ports
`default_nettype none

module pse_stack_mem
    import pse_pkg::*;
#(
    parameter int DEPTH = DEFAULT_STACK_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [WORD_W-1:0] rd_data_a,
    output logic      [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

/* src/pse_alu.sv */
// shared arithmetic unit: add, sub, mul and radix-2 signed divide and modulo
`default_nettype none

module pse_alu
    import pse_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire alu_req_t          req,
    input  wire logic [WORD_W-1:0] lhs,
    input  wire logic [WORD_W-1:0] rhs,
    output alu_rsp_t               rsp
);

    localparam int ITER_W = $clog2(WORD_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_W - 1);

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_SIGN,
        A_FIN
    } alu_state_t;

    alu_state_t        state_reg, state_next;
    logic              is_mod_reg, is_mod_next;
    logic              q_neg_reg, q_neg_next;
    logic              r_neg_reg, r_neg_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [WORD_W-1:0] result_reg, result_next;

    logic [WORD_W-1:0] lhs_abs;
    logic [WORD_W-1:0] rhs_abs;
    logic [WORD_W-1:0] product;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;
    logic              take;

    assign lhs_abs   = lhs[WORD_W-1] ? (~lhs + WORD_W'(1)) : lhs;
    assign rhs_abs   = rhs[WORD_W-1] ? (~rhs + WORD_W'(1)) : rhs;
    assign product   = lhs * rhs;
    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};
    assign take      = ~diff[WORD_W];

    always_comb begin
        state_next  = state_reg;
        is_mod_next = is_mod_reg;
        q_neg_next  = q_neg_reg;
        r_neg_next  = r_neg_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        iter_next   = iter_reg;
        result_next = result_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        ALU_ADD: begin
                            result_next = lhs + rhs;
                            state_next  = A_FIN;
                        end
                        ALU_SUB: begin
                            result_next = lhs - rhs;
                            state_next  = A_FIN;
                        end
                        ALU_MUL: begin
                            result_next = product;
                            state_next  = A_FIN;
                        end
                        ALU_DIV, ALU_MOD: begin
                            is_mod_next = (req.op == ALU_MOD);
                            q_neg_next  = lhs[WORD_W-1] ^ rhs[WORD_W-1];
                            r_neg_next  = lhs[WORD_W-1];
                            quo_next    = lhs_abs;
                            dvs_next    = rhs_abs;
                            rem_next    = '0;
                            iter_next   = '0;
                            state_next  = A_DIV;
                        end
                        default: begin
                            result_next = '0;
                            state_next  = A_FIN;
                        end
                    endcase
                end
            end
            A_DIV: begin
                // quotient bits shift in where dividend bits shift out
                rem_next  = take ? diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
                quo_next  = {quo_reg[WORD_W-2:0], take};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST) begin
                    state_next = A_SIGN;
                end
            end
            A_SIGN: begin
                if (is_mod_reg) begin
                    result_next = r_neg_reg ? (~rem_reg + WORD_W'(1)) : rem_reg;
                end else begin
                    result_next = q_neg_reg ? (~quo_reg + WORD_W'(1)) : quo_reg;
                end
                state_next = A_FIN;
            end
            A_FIN: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        is_mod_reg <= is_mod_next;
        q_neg_reg  <= q_neg_next;
        r_neg_reg  <= r_neg_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        iter_reg   <= iter_next;
        result_reg <= result_next;
    end

    assign rsp.done   = (state_reg == A_FIN);
    assign rsp.result = result_reg;

endmodule

`default_nettype wire
